FILE: src/stripe_shader_pixel_generator_assert.svh
// Assertion macros shared by the checker of the stripe shader pixel generator.
`ifndef STRIPE_SHADER_PIXEL_GENERATOR_ASSERT_SVH
`define STRIPE_SHADER_PIXEL_GENERATOR_ASSERT_SVH

// Same-cycle implication.
`define SSPG_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sspg assertion failed");

// Next-cycle implication.
`define SSPG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sspg assertion failed");

// Implication with the delay given by the argument n.
`define SSPG_ASSERT_LAT(lbl, clk, rst_n, ante, n, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
        else $error("sspg assertion failed");

`endif

FILE: src/sspg_pkg.sv
// Types, constants and the sine table generator of the stripe shader pixel generator.
`timescale 1ns / 1ps

package sspg_pkg;

    localparam int COORD_W    = 12;
    localparam int DIM_W      = 13;
    localparam int NORM_W     = 16;
    localparam int DIV_STAGES = 4;
    localparam int DIV_STEPS  = NORM_W / DIV_STAGES;

    localparam int TURN_W      = 16;
    localparam int PHASE_W     = 26;
    localparam int PHASE_SHIFT = 24;
    localparam int PROD_W      = NORM_W + 1 + PHASE_W;
    localparam logic [PHASE_W-1:0] PHASE_K      = 26'd53403537;
    localparam logic [TURN_W-1:0]  QUARTER_TURN = 16'h4000;

    localparam int SINE_ENTRIES = 1024;
    localparam int SINE_AW      = $clog2(SINE_ENTRIES);
    localparam int IDX_SHIFT    = TURN_W - 2 - SINE_AW;
    localparam int BANK_AW      = 8;
    localparam int BANK_DEPTH   = 1 << BANK_AW;
    localparam int N_BANKS      = SINE_ENTRIES / BANK_DEPTH;
    localparam int SEL_W        = SINE_AW - BANK_AW;
    localparam int SAMPLE_W     = 15;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    localparam int CHAN_W = 8;
    localparam logic [CHAN_W-1:0] ALPHA = 8'hFF;
    localparam logic [TURN_W:0]   BIAS  = 17'd32768;

    localparam int ADDR_W     = 24;
    localparam int PROD_A_W   = COORD_W + DIM_W;
    localparam int PIPE_DEPTH = 8;
    localparam int ADDR_DELAY = PIPE_DEPTH - 2;

    localparam int CFG_IDX_W = 2;
    localparam logic [DIM_W-1:0] CFG_RESET = 13'd512;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_STRIDE = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [COORD_W-1:0] pixel_x;
        logic [COORD_W-1:0] pixel_y;
    } t_pix_in;

    typedef struct packed {
        logic [31:0]       pixel_word;
        logic [ADDR_W-1:0] store_address;
    } t_pix_out;

    function automatic logic [SAMPLE_W-1:0] sine_rom_val(input int unsigned i);
        int unsigned      v_i;
        longint unsigned  v_a;
        longint unsigned  v_x2;
        longint unsigned  v_term;
        longint           v_sum;
        longint unsigned  v_val;
        v_i    = (i > SINE_ENTRIES) ? SINE_ENTRIES : i;
        v_a    = (HALF_PI_Q30 * longint'(v_i)) / SINE_ENTRIES;
        v_x2   = (v_a * v_a) >> 30;
        v_sum  = longint'(v_a);
        v_term = ((v_a * v_x2) >> 30) / 6;
        v_sum  = v_sum - longint'(v_term);
        v_term = ((v_term * v_x2) >> 30) / 20;
        v_sum  = v_sum + longint'(v_term);
        v_term = ((v_term * v_x2) >> 30) / 42;
        v_sum  = v_sum - longint'(v_term);
        v_term = ((v_term * v_x2) >> 30) / 72;
        v_sum  = v_sum + longint'(v_term);
        v_term = ((v_term * v_x2) >> 30) / 110;
        v_sum  = v_sum - longint'(v_term);
        if (v_sum < 0) begin
            v_sum = 0;
        end
        v_val = (longint'(v_sum) * 64'd32767 + 64'd536870912) >> 30;
        if (v_val > 64'd32767) begin
            v_val = 64'd32767;
        end
        return v_val[SAMPLE_W-1:0];
    endfunction

    localparam logic [SAMPLE_W-1:0] ROM_TOP = sine_rom_val(SINE_ENTRIES);

endpackage

FILE: src/sspg_rom_bank.sv
// One bank of the quarter-wave sine table with registered read.
`timescale 1ns / 1ps

module sspg_rom_bank import sspg_pkg::*; #(
    parameter int unsigned BASE = 0
) (
    input  logic                i_clk,
    input  logic [BANK_AW-1:0]  i_addr,
    output logic [SAMPLE_W-1:0] o_data
);

    logic [SAMPLE_W-1:0] w_rom [BANK_DEPTH];
    logic [SAMPLE_W-1:0] r_data;

    for (genvar i = 0; i < BANK_DEPTH; i++) begin : g_entry
        assign w_rom[i] = sine_rom_val(BASE + i);
    end

    always_ff @(posedge i_clk) begin
        r_data <= w_rom[i_addr];
    end

    assign o_data = r_data;

endmodule

FILE: src/sspg_sine.sv
// Two-stage sine lookup from a phase in turns to an 8-bit color channel.
`timescale 1ns / 1ps

module sspg_sine import sspg_pkg::*; (
    input  logic              i_clk,
    input  logic [TURN_W-1:0] i_turns,
    output logic [CHAN_W-1:0] o_channel
);

    logic [1:0]               w_quad;
    logic [SINE_AW-1:0]       w_idx;
    logic [SINE_AW:0]         w_addr;
    logic [SAMPLE_W-1:0]      w_bank [N_BANKS];
    logic [SEL_W-1:0]         r_sel;
    logic                     r_top;
    logic                     r_neg;
    logic [SAMPLE_W-1:0]      w_mag;
    logic [TURN_W-1:0]        w_biased;
    logic [TURN_W+CHAN_W-1:0] w_scaled;
    logic [CHAN_W-1:0]        r_channel;

    assign w_quad = i_turns[TURN_W-1 -: 2];
    assign w_idx  = i_turns[TURN_W-3 -: SINE_AW];
    assign w_addr = w_quad[0] ? (SINE_AW+1)'(SINE_ENTRIES) - {1'b0, w_idx} : {1'b0, w_idx};

    for (genvar b = 0; b < N_BANKS; b++) begin : g_bank
        sspg_rom_bank #(
            .BASE (b * BANK_DEPTH)
        ) u_bank (
            .i_clk  (i_clk),
            .i_addr (w_addr[BANK_AW-1:0]),
            .o_data (w_bank[b])
        );
    end

    always_ff @(posedge i_clk) begin
        r_sel <= w_addr[SINE_AW-1:BANK_AW];
        r_top <= w_addr[SINE_AW];
        r_neg <= w_quad[1];
    end

    assign w_mag    = r_top ? ROM_TOP : w_bank[r_sel];
    assign w_biased = r_neg ? TURN_W'(BIAS - (TURN_W+1)'(w_mag))
                            : TURN_W'(BIAS + (TURN_W+1)'(w_mag));
    assign w_scaled = {w_biased, {CHAN_W{1'b0}}} - (TURN_W+CHAN_W)'(w_biased);

    always_ff @(posedge i_clk) begin
        r_channel <= w_scaled[TURN_W+CHAN_W-1 -: CHAN_W];
    end

    assign o_channel = r_channel;

endmodule

FILE: src/sspg_div.sv
// Pipelined restoring divider forming a Q0.16 normalized coordinate.
`timescale 1ns / 1ps

module sspg_div import sspg_pkg::*; (
    input  logic               i_clk,
    input  logic [COORD_W-1:0] i_coord,
    input  logic [DIM_W-1:0]   i_dim,
    output logic [NORM_W-1:0]  o_norm
);

    logic [DIM_W-1:0]  w_rem_in [DIV_STAGES];
    logic [NORM_W-1:0] w_q_in   [DIV_STAGES];
    logic              w_sat_in [DIV_STAGES];
    logic [DIM_W-1:0]  n_rem    [DIV_STAGES];
    logic [NORM_W-1:0] n_q      [DIV_STAGES];
    logic [DIM_W-1:0]  r_rem    [DIV_STAGES];
    logic [NORM_W-1:0] r_q      [DIV_STAGES];
    logic              r_sat    [DIV_STAGES];

    assign w_rem_in[0] = {1'b0, i_coord};
    assign w_q_in[0]   = '0;
    assign w_sat_in[0] = ({1'b0, i_coord} >= i_dim);

    for (genvar g = 1; g < DIV_STAGES; g++) begin : g_link
        assign w_rem_in[g] = r_rem[g-1];
        assign w_q_in[g]   = r_q[g-1];
        assign w_sat_in[g] = r_sat[g-1];
    end

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
        always_comb begin
            logic [DIM_W-1:0]  v_rem;
            logic [NORM_W-1:0] v_q;
            logic [DIM_W:0]    v_part;
            v_rem = w_rem_in[g];
            v_q   = w_q_in[g];
            for (int j = 0; j < DIV_STEPS; j++) begin
                v_part = {v_rem, 1'b0};
                if (v_part >= {1'b0, i_dim}) begin
                    v_part = v_part - {1'b0, i_dim};
                    v_q    = {v_q[NORM_W-2:0], 1'b1};
                end else begin
                    v_q    = {v_q[NORM_W-2:0], 1'b0};
                end
                v_rem = v_part[DIM_W-1:0];
            end
            n_rem[g] = v_rem;
            n_q[g]   = v_q;
        end

        always_ff @(posedge i_clk) begin
            r_rem[g] <= n_rem[g];
            r_q[g]   <= n_q[g];
            r_sat[g] <= w_sat_in[g];
        end
    end

    assign o_norm = r_sat[DIV_STAGES-1] ? '1 : r_q[DIV_STAGES-1];

endmodule

FILE: src/stripe_shader_pixel_generator.sv
// Top level of the stripe shader pixel generator.
`timescale 1ns / 1ps

// Usage:
//   Pixel channel: drive i_pixel and raise start; the pixel is taken at a rising edge
//   where start is high and busy is low. busy is low at all times out of reset, so a
//   new pixel may be taken on every clock.
//   Result channel: o_strobe is high for one cycle with o_result holding the color
//   word and the store address; the result is taken at the edge that ends that cycle.
//   Pipeline: a pixel passes the input registers, the four-stage divider, the phase
//   multiply stage and the two-stage sine table read, all fully pipelined. Throughput
//   is one pixel per clock.
//   Configuration: i_cfg_valid / o_cfg_ready with i_cfg_index and i_cfg_data write
//   image width (0), image height (1) and row stride (2); other indexes are dropped.
//   Write only while no pixel is in flight.
//   Reset: synchronous, active low. Clears the in-flight valid bits, loads 512 into
//   all three registers, and holds busy high and o_cfg_ready low until the first
//   edge after reset is released.
//   The receiver cannot stall; results are never held.

module stripe_shader_pixel_generator import sspg_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  t_pix_in              i_pixel,
    output logic                 o_strobe,
    output t_pix_out             o_result,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DIM_W-1:0]     i_cfg_data
);

    logic                  r_live;
    logic [DIM_W-1:0]      r_width;
    logic [DIM_W-1:0]      r_height;
    logic [DIM_W-1:0]      r_stride;
    logic [PIPE_DEPTH-1:0] r_vld;
    logic [COORD_W-1:0]    r_x;
    logic [COORD_W-1:0]    r_y;
    logic [COORD_W-1:0]    r_x_d;
    logic [PROD_A_W-1:0]   r_prod;
    logic [ADDR_W-1:0]     r_addr_d [ADDR_DELAY];
    logic [DIM_W-1:0]      w_width_eff;
    logic [DIM_W-1:0]      w_height_eff;
    logic [NORM_W-1:0]     w_u;
    logic [NORM_W-1:0]     w_v;
    logic [NORM_W:0]       w_sum;
    logic [PROD_W-1:0]     w_prod_r;
    logic [PROD_W-1:0]     w_prod_g;
    logic [PROD_W-1:0]     w_prod_b;
    logic [TURN_W-1:0]     r_turn_r;
    logic [TURN_W-1:0]     r_turn_g;
    logic [TURN_W-1:0]     r_turn_b;
    logic [CHAN_W-1:0]     w_red;
    logic [CHAN_W-1:0]     w_green;
    logic [CHAN_W-1:0]     w_blue;
    logic                  w_accept;

    assign busy        = !r_live;
    assign o_cfg_ready = r_live;
    assign w_accept    = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live   <= 1'b0;
            r_width  <= CFG_RESET;
            r_height <= CFG_RESET;
            r_stride <= CFG_RESET;
            r_vld    <= '0;
        end else begin
            r_live <= 1'b1;
            r_vld  <= {r_vld[PIPE_DEPTH-2:0], w_accept};
            if (i_cfg_valid && r_live) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_WIDTH: begin
                        r_width <= i_cfg_data;
                    end
                    CFG_HEIGHT: begin
                        r_height <= i_cfg_data;
                    end
                    CFG_STRIDE: begin
                        r_stride <= i_cfg_data;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_x         <= i_pixel.pixel_x;
        r_y         <= i_pixel.pixel_y;
        r_x_d       <= r_x;
        r_prod      <= PROD_A_W'(r_y) * PROD_A_W'(r_stride);
        r_addr_d[0] <= ADDR_W'(r_prod + PROD_A_W'(r_x_d));
        for (int k = 1; k < ADDR_DELAY; k++) begin
            r_addr_d[k] <= r_addr_d[k-1];
        end
    end

    assign w_width_eff  = (r_width == '0) ? DIM_W'(1) : r_width;
    assign w_height_eff = (r_height == '0) ? DIM_W'(1) : r_height;

    sspg_div u_div_x (
        .i_clk   (i_clk),
        .i_coord (r_x),
        .i_dim   (w_width_eff),
        .o_norm  (w_u)
    );

    sspg_div u_div_y (
        .i_clk   (i_clk),
        .i_coord (r_y),
        .i_dim   (w_height_eff),
        .o_norm  (w_v)
    );

    assign w_sum    = {1'b0, w_u} + {1'b0, w_v};
    assign w_prod_r = PROD_W'(w_u) * PROD_W'(PHASE_K);
    assign w_prod_g = PROD_W'(w_sum) * PROD_W'(PHASE_K);
    assign w_prod_b = PROD_W'(w_v) * PROD_W'(PHASE_K);

    always_ff @(posedge i_clk) begin
        r_turn_r <= w_prod_r[PHASE_SHIFT +: TURN_W];
        r_turn_g <= w_prod_g[PHASE_SHIFT +: TURN_W];
        r_turn_b <= w_prod_b[PHASE_SHIFT +: TURN_W] + QUARTER_TURN;
    end

    sspg_sine u_sine_red (
        .i_clk     (i_clk),
        .i_turns   (r_turn_r),
        .o_channel (w_red)
    );

    sspg_sine u_sine_green (
        .i_clk     (i_clk),
        .i_turns   (r_turn_g),
        .o_channel (w_green)
    );

    sspg_sine u_sine_blue (
        .i_clk     (i_clk),
        .i_turns   (r_turn_b),
        .o_channel (w_blue)
    );

    assign o_strobe               = r_vld[PIPE_DEPTH-1];
    assign o_result.pixel_word    = {ALPHA, w_blue, w_green, w_red};
    assign o_result.store_address = r_addr_d[ADDR_DELAY-1];

endmodule

FILE: src/sspg_checker.sv
// Port-level checker of the stripe shader pixel generator and its bind.
`timescale 1ns / 1ps
`include "stripe_shader_pixel_generator_assert.svh"

module sspg_checker import sspg_pkg::*; (
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     start,
    input logic     busy,
    input logic     o_strobe,
    input t_pix_out o_result,
    input logic     o_cfg_ready
);

    `SSPG_ASSERT_LAT(a_word_follows, i_clk, i_rst_n, start && !busy, PIPE_DEPTH, o_strobe)
    `SSPG_ASSERT_IMP(a_no_spurious, i_clk, i_rst_n, o_strobe, $past(start && !busy, PIPE_DEPTH))
    `SSPG_ASSERT_IMP(a_alpha_full, i_clk, i_rst_n, o_strobe, o_result.pixel_word[31:24] == ALPHA)
    `SSPG_ASSERT_NEXT(a_ready_tracks, i_clk, i_rst_n, 1'b1, o_cfg_ready && !busy)

endmodule

bind stripe_shader_pixel_generator sspg_checker u_sspg_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_strobe    (o_strobe),
    .o_result    (o_result),
    .o_cfg_ready (o_cfg_ready)
);
